### src/lsw_pkg.sv
`timescale 1ns / 1ps

package lsw_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int NUM_LANES   = 5;

	localparam int SUM_W    = SAMPLE_BITS + 3;
	localparam int OFF_W    = SAMPLE_BITS + 1;
	localparam int SQ_W     = 2 * SAMPLE_BITS;
	localparam int SPREAD_W = SQ_W + 3;

	// Floor division of the sum by five: multiply by a rounded-up reciprocal.
	// The extra four fraction bits keep the error below one fifth for any sum.
	localparam int RECIP_SHIFT = SUM_W + 4;
	localparam int RECIP_W     = SUM_W + 2;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) / 5) + 1);

	localparam int LIMIT_W = 27;
	localparam int THR_W   = 13;
	localparam int CMP_W   = (SPREAD_W > LIMIT_W) ? SPREAD_W : LIMIT_W;
	localparam int OCMP_W  = (OFF_W > THR_W) ? OFF_W : THR_W;

	localparam logic [LIMIT_W-1:0]      LIMIT_RESET = LIMIT_W'(40000);
	localparam logic signed [THR_W-1:0] AWAY_RESET  = THR_W'(200);
	localparam logic signed [THR_W-1:0] CLOSE_RESET = THR_W'(600);

	localparam int IN_TDATA_W  = ((NUM_LANES * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = LIMIT_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPREAD_LIMIT = 2'd0,
		REG_AWAY_LIMIT   = 2'd1,
		REG_CLOSE_LIMIT  = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		CLS_IN_RANGE = 2'd0,
		CLS_CLOSE    = 2'd1,
		CLS_AWAY     = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		CMD_STOP    = 3'd0,
		CMD_FORWARD = 3'd1,
		CMD_LEFT    = 3'd2,
		CMD_RIGHT   = 3'd3,
		CMD_HOLD    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]      spread_limit;
		logic signed [THR_W-1:0] away_limit;
		logic signed [THR_W-1:0] close_limit;
	} lsw_cfg_t;

	// Lowest bits first: command, spread_low, right, front right, front, front left, left.
	typedef struct packed {
		class_t cls_left;
		class_t cls_front_left;
		class_t cls_front;
		class_t cls_front_right;
		class_t cls_right;
		logic   spread_low;
		cmd_t   cmd;
	} lsw_result_t;

	localparam int RES_W = $bits(lsw_result_t);

endpackage

### src/lsw_lane.sv
`timescale 1ns / 1ps

module lsw_lane
	import lsw_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic [SAMPLE_BITS-1:0]  mean,
	output logic signed [OFF_W-1:0] offset_s3,
	output logic [SQ_W-1:0]         square_s3
);

	logic signed [OFF_W-1:0]   offset;
	logic signed [2*OFF_W-1:0] product;

	always_comb begin
		offset  = signed'({1'b0, sample}) - signed'({1'b0, mean});
		product = offset * offset;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offset_s3 <= offset;
			square_s3 <= product[SQ_W-1:0];
		end
	end

endmodule

### src/lsw_merge.sv
`timescale 1ns / 1ps

module lsw_merge
	import lsw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsw_cfg_t                cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [OFF_W-1:0] offset [NUM_LANES],
	input  logic [SQ_W-1:0]         square [NUM_LANES],
	output logic                    out_valid,
	input  logic                    out_ready,
	output lsw_result_t             result
);

	logic [NUM_LANES-1:0][1:0] class_q;
	logic [NUM_LANES-1:0][1:0] class_next;
	logic [SPREAD_W-1:0]       spread;
	logic                      held;
	logic                      load;
	logic signed [OCMP_W-1:0]  off_x;
	logic signed [OCMP_W-1:0]  away_x;
	logic signed [OCMP_W-1:0]  close_x;
	class_t                    r, fr, f, fl, l;
	cmd_t                      cmd;
	logic                      out_valid_q;
	lsw_result_t               result_q;

	assign in_ready = !out_valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		spread = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			spread = spread + SPREAD_W'(square[i]);
		end
		held = CMP_W'(spread) < CMP_W'(cfg.spread_limit);

		away_x  = OCMP_W'(cfg.away_limit);
		close_x = OCMP_W'(cfg.close_limit);
		off_x   = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			off_x = OCMP_W'(offset[i]);
			if (held) begin
				class_next[i] = class_q[i];
			end else if (off_x < away_x) begin
				class_next[i] = CLS_AWAY;
			end else if (off_x > close_x) begin
				class_next[i] = CLS_CLOSE;
			end else begin
				class_next[i] = CLS_IN_RANGE;
			end
		end

		r  = class_t'(class_next[0]);
		fr = class_t'(class_next[1]);
		f  = class_t'(class_next[2]);
		fl = class_t'(class_next[3]);
		l  = class_t'(class_next[4]);

		if (f == CLS_CLOSE) begin
			cmd = CMD_STOP;
		end else if ((r == CLS_IN_RANGE && l == CLS_IN_RANGE) ||
			(r == CLS_CLOSE && l == CLS_CLOSE)) begin
			cmd = CMD_FORWARD;
		end else if (r == CLS_CLOSE || fr != CLS_AWAY) begin
			cmd = CMD_LEFT;
		end else if (l == CLS_CLOSE || fl != CLS_AWAY) begin
			cmd = CMD_RIGHT;
		end else begin
			cmd = CMD_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_LANES; i++) begin
				class_q[i] <= CLS_AWAY;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				class_q     <= class_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.cmd             <= cmd;
			result_q.spread_low      <= held;
			result_q.cls_right       <= r;
			result_q.cls_front_right <= fr;
			result_q.cls_front       <= f;
			result_q.cls_front_left  <= fl;
			result_q.cls_left        <= l;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// A held request must leave the stored sensor states untouched.
	a_held_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(load && held) |=> $stable(class_q))
		else $error("sensor states changed on a held request");

	// A close front sensor always wins over every other rule.
	a_front_close_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.cls_front == CLS_CLOSE) |-> (result_q.cmd == CMD_STOP))
		else $error("front sensor close without a stop command");

	// No change is only reported when both front diagonals see nothing.
	a_hold_needs_away: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.cmd == CMD_HOLD) |->
		(result_q.cls_front_right == CLS_AWAY && result_q.cls_front_left == CLS_AWAY &&
		result_q.cls_front != CLS_CLOSE))
		else $error("no-change command with a diagonal sensor not away");

	// The result register's right and left classes match the stored states after its request.
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_q.cls_right == class_t'(class_q[0]) &&
		result_q.cls_left == class_t'(class_q[4])))
		else $error("result classes differ from stored states");

endmodule

### src/light_sensor_wall_steering.sv
`timescale 1ns / 1ps

// Wall steering from five light sensors. Each request on s_axis carries one scan
// (right, front right, front, front left, left); the block forms the truncated mean,
// each sensor's offset from it and the sum of squared offsets, re-classes the sensors
// unless that spread is below the spread limit, and returns one motor command with the
// stored sensor states on m_axis. One request is taken every clock cycle unless m_axis
// stalls. The stages are the sum, the reciprocal multiply for the mean, the per-sensor
// squaring lanes and the merge with its output register. Users must write limits
// through the cfg port only while no request is in flight; the block does not enforce it.
module light_sensor_wall_steering
	import lsw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// sample_right, sample_front_right, sample_front, sample_front_left, sample_left
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// motor_command, spread_low, class_right, class_front_right, class_front,
	// class_front_left, class_left
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	lsw_cfg_t                   cfg_q;
	logic [SAMPLE_BITS-1:0]     sample [NUM_LANES];
	logic [SUM_W-1:0]           sum;
	logic [SAMPLE_BITS-1:0]     sample_s1 [NUM_LANES];
	logic [SUM_W-1:0]           sum_s1;
	logic [PROD_W-1:0]          prod;
	logic [SAMPLE_BITS-1:0]     sample_s2 [NUM_LANES];
	logic [SAMPLE_BITS-1:0]     mean_s2;
	logic signed [OFF_W-1:0]    offset_s3 [NUM_LANES];
	logic [SQ_W-1:0]            square_s3 [NUM_LANES];
	logic                       v1_q, v2_q, v3_q;
	logic                       adv2, adv3, merge_ready;
	lsw_result_t                result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spread_limit <= LIMIT_RESET;
			cfg_q.away_limit   <= AWAY_RESET;
			cfg_q.close_limit  <= CLOSE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPREAD_LIMIT: cfg_q.spread_limit <= cfg_wdata[LIMIT_W-1:0];
				REG_AWAY_LIMIT:   cfg_q.away_limit   <= cfg_wdata[THR_W-1:0];
				REG_CLOSE_LIMIT:  cfg_q.close_limit  <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv3     = !v3_q || merge_ready;
	assign adv2     = !v2_q || adv3;
	assign s_tready = !v1_q || adv2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			sample[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
			sum       = sum + SUM_W'(sample[i]);
		end
		prod = PROD_W'(sum_s1) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v1_q <= s_tvalid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			sample_s1 <= sample;
			sum_s1    <= sum;
		end
		if (adv2) begin
			sample_s2 <= sample_s1;
			mean_s2   <= prod[RECIP_SHIFT +: SAMPLE_BITS];
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		lsw_lane u_lane (
			.clk       (clk),
			.en        (adv3),
			.sample    (sample_s2[g]),
			.mean      (mean_s2),
			.offset_s3 (offset_s3[g]),
			.square_s3 (square_s3[g])
		);
	end

	lsw_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v3_q),
		.in_ready  (merge_ready),
		.offset    (offset_s3),
		.square    (square_s3),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, result};

endmodule
